// ===== src/conv3_pkg.sv =====
`default_nettype none

package conv3_pkg;

    // frame limits and arithmetic format
    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int COEF_FRAC_BITS = 8;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int SIZE_W   = 11;
    localparam int REGION_W = 10;
    localparam int PIX_W    = 8;
    localparam int COEF_W   = 16;
    localparam int TAPS     = 9;
    localparam int PROD_W   = PIX_W + 1 + COEF_W;
    localparam int ACC_W    = PROD_W + 3;
    localparam int Q_W      = ACC_W - COEF_FRAC_BITS;
    localparam int KROW_W   = 3 * COEF_W;
    localparam int LINE_W   = 2 * PIX_W;

    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    localparam int OUT_DATA_W = 32;
    localparam int IN_DATA_W  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_REGION_ROW    = 3'd2,
        CFG_REGION_COL    = 3'd3,
        CFG_MAX_SAMPLE    = 3'd4,
        CFG_KERNEL_TOP    = 3'd5,
        CFG_KERNEL_MIDDLE = 3'd6,
        CFG_KERNEL_BOTTOM = 3'd7
    } t_cfg_idx;

    // live configuration, sizes already saturated
    typedef struct packed {
        logic [SIZE_W-1:0]            width;
        logic [SIZE_W-1:0]            height;
        logic [REGION_W-1:0]          region_row;
        logic [REGION_W-1:0]          region_col;
        logic [PIX_W-1:0]             max_sample;
        logic [TAPS-1:0][COEF_W-1:0]  coef;   // tap i*3+j = row i, column j
    } t_cfg;

    // position of the beat just taken and whether it yields a result
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             emit;
    } t_pos;

endpackage

`default_nettype wire

// ===== src/conv3x3_clamped_filter.sv =====
`default_nettype none

// channel   dir  handshake                 payload (low bit up)
// -------   ---  ------------------------  ------------------------------------------
// s (pix)   in   i_s_tvalid / o_s_tready    i_s_tdata[7:0] pixel
// m (res)   out  o_m_tvalid / i_m_tready    o_m_tdata[9:0] out_row, [19:10] out_col,
//                                           [27:20] out_value, [31:28] zero
// cfg       in   i_cfg_we (no wait)         i_cfg_index, i_cfg_data[47:0]
//
// one pixel beat per cycle sustained while no stall backs up from the result side; a result
// passes through the registered line buffer read, the product stage, the sum stage and the
// output register
// reset: counters, window, configuration and valid flags go to their reset values; line buffer
// contents are unknown until written and need no clearing pass
// a stall on the result side backs up only as far as the stages that are full

module conv3x3_clamped_filter (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire  [conv3_pkg::IN_DATA_W-1:0]     i_s_tdata,   // [7:0] pixel
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    output logic [conv3_pkg::OUT_DATA_W-1:0]    o_m_tdata,   // out_row, out_col, out_value
    input  wire                                 i_cfg_we,
    input  wire  [conv3_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [conv3_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    conv3_pkg::t_cfg cfg;
    conv3_pkg::t_pos pos;

    logic accept;
    logic pass1;
    logic mac_ready;

    // stage 1: pixel beat waiting for its line buffer word
    logic                          r_v1;
    logic                          r_emit1;
    logic [conv3_pkg::PIX_W-1:0]   r_px1;
    logic [conv3_pkg::ROW_W-1:0]   r_row1;
    logic [conv3_pkg::COL_W-1:0]   r_col1;
    logic [conv3_pkg::LINE_W-1:0]  line_rd;

    logic                          res_valid;
    logic [conv3_pkg::ROW_W-1:0]   res_row;
    logic [conv3_pkg::COL_W-1:0]   res_col;
    logic [conv3_pkg::PIX_W-1:0]   res_value;

    conv3_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // raster counters and the emit decision for the beat on the input
    conv3_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cfg    (cfg),
        .o_pos    (pos)
    );

    // stage 1 drains whenever its beat yields nothing or the product stage has room
    assign pass1      = r_v1 && (!r_emit1 || mac_ready);
    assign o_s_tready = !r_v1 || pass1;
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_s_tready) begin
            r_v1 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px1   <= i_s_tdata[conv3_pkg::PIX_W-1:0];
            r_row1  <= pos.row;
            r_col1  <= pos.col;
            r_emit1 <= pos.emit;
        end
    end

    // read at the new column as the beat lands; rotate the column when it leaves
    conv3_line_ram u_line (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (pos.col),
        .o_rd_data (line_rd),
        .i_wr_en   (pass1),
        .i_wr_addr (r_col1),
        .i_wr_data ({line_rd[conv3_pkg::PIX_W-1:0], r_px1})
    );

    // window, products, sum and clamp
    conv3_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_load   (pass1),
        .i_emit   (r_emit1),
        .i_two_up (line_rd[conv3_pkg::LINE_W-1:conv3_pkg::PIX_W]),
        .i_one_up (line_rd[conv3_pkg::PIX_W-1:0]),
        .i_px     (r_px1),
        .i_row    (r_row1),
        .i_col    (r_col1),
        .o_ready  (mac_ready),
        .o_valid  (res_valid),
        .i_ready  (i_m_tready),
        .o_row    (res_row),
        .o_col    (res_col),
        .o_value  (res_value)
    );

    assign o_m_tvalid = res_valid;
    assign o_m_tdata  = {{(conv3_pkg::OUT_DATA_W - conv3_pkg::ROW_W - conv3_pkg::COL_W
                           - conv3_pkg::PIX_W){1'b0}},
                         res_value, res_col, res_row};

`ifndef SYNTHESIS
    // the column being written back never collides with the one being read
    a_line_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pass1 && accept) |-> (r_col1 != pos.col))
        else $error("line buffer read and write hit the same column");
`endif

endmodule

`default_nettype wire

// ===== src/conv3_cfg.sv =====
`default_nettype none

module conv3_cfg (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [conv3_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [conv3_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output conv3_pkg::t_cfg                       o_cfg
);

    logic [conv3_pkg::SIZE_W-1:0]   r_width;
    logic [conv3_pkg::SIZE_W-1:0]   r_height;
    logic [conv3_pkg::REGION_W-1:0] r_region_row;
    logic [conv3_pkg::REGION_W-1:0] r_region_col;
    logic [conv3_pkg::PIX_W-1:0]    r_max_sample;
    logic [conv3_pkg::KROW_W-1:0]   r_kern [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= conv3_pkg::SIZE_W'(conv3_pkg::MAX_WIDTH);
            r_height     <= conv3_pkg::SIZE_W'(conv3_pkg::MAX_HEIGHT);
            r_region_row <= '0;
            r_region_col <= '0;
            r_max_sample <= '1;
            r_kern[0]    <= '0;
            r_kern[1]    <= conv3_pkg::KROW_W'(1 << conv3_pkg::COEF_FRAC_BITS);
            r_kern[2]    <= '0;
        end else if (i_cfg_we) begin
            unique case (conv3_pkg::t_cfg_idx'(i_cfg_index))
                conv3_pkg::CFG_IMAGE_WIDTH:   r_width      <= i_cfg_data[conv3_pkg::SIZE_W-1:0];
                conv3_pkg::CFG_IMAGE_HEIGHT:  r_height     <= i_cfg_data[conv3_pkg::SIZE_W-1:0];
                conv3_pkg::CFG_REGION_ROW:    r_region_row <= i_cfg_data[conv3_pkg::REGION_W-1:0];
                conv3_pkg::CFG_REGION_COL:    r_region_col <= i_cfg_data[conv3_pkg::REGION_W-1:0];
                conv3_pkg::CFG_MAX_SAMPLE:    r_max_sample <= i_cfg_data[conv3_pkg::PIX_W-1:0];
                conv3_pkg::CFG_KERNEL_TOP:    r_kern[0]    <= i_cfg_data[conv3_pkg::KROW_W-1:0];
                conv3_pkg::CFG_KERNEL_MIDDLE: r_kern[1]    <= i_cfg_data[conv3_pkg::KROW_W-1:0];
                conv3_pkg::CFG_KERNEL_BOTTOM: r_kern[2]    <= i_cfg_data[conv3_pkg::KROW_W-1:0];
            endcase
        end
    end

    // saturate sizes into the supported range
    always_comb begin
        if (r_width < conv3_pkg::SIZE_W'(3)) begin
            o_cfg.width = conv3_pkg::SIZE_W'(3);
        end else if (r_width > conv3_pkg::SIZE_W'(conv3_pkg::MAX_WIDTH)) begin
            o_cfg.width = conv3_pkg::SIZE_W'(conv3_pkg::MAX_WIDTH);
        end else begin
            o_cfg.width = r_width;
        end
        if (r_height < conv3_pkg::SIZE_W'(3)) begin
            o_cfg.height = conv3_pkg::SIZE_W'(3);
        end else if (r_height > conv3_pkg::SIZE_W'(conv3_pkg::MAX_HEIGHT)) begin
            o_cfg.height = conv3_pkg::SIZE_W'(conv3_pkg::MAX_HEIGHT);
        end else begin
            o_cfg.height = r_height;
        end
        o_cfg.region_row = r_region_row;
        o_cfg.region_col = r_region_col;
        o_cfg.max_sample = r_max_sample;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                o_cfg.coef[i*3+j] = r_kern[i][j*conv3_pkg::COEF_W +: conv3_pkg::COEF_W];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/conv3_scan.sv =====
`default_nettype none

module conv3_scan (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_accept,
    input  conv3_pkg::t_cfg  i_cfg,
    output conv3_pkg::t_pos  o_pos
);

    localparam int W = conv3_pkg::SIZE_W;

    logic [conv3_pkg::COL_W-1:0] r_col;
    logic [conv3_pkg::ROW_W-1:0] r_row;
    logic [conv3_pkg::COL_W-1:0] n_col;
    logic [conv3_pkg::ROW_W-1:0] n_row;

    logic [W-1:0] row_a;
    logic [W-1:0] row_0;
    logic [W-1:0] col_0;
    logic [W-1:0] col_n;
    logic [W-1:0] row_n;

    always_comb begin
        // wrap first in case the size shrank since the last beat
        if (W'(r_col) >= i_cfg.width) begin
            col_0 = '0;
            row_a = W'(r_row) + W'(1);
        end else begin
            col_0 = W'(r_col);
            row_a = W'(r_row);
        end
        row_0 = (row_a >= i_cfg.height) ? '0 : row_a;

        o_pos.row  = row_0[conv3_pkg::ROW_W-1:0];
        o_pos.col  = col_0[conv3_pkg::COL_W-1:0];
        o_pos.emit = (row_0 >= W'(i_cfg.region_row) + W'(2))
                  && (col_0 >= W'(i_cfg.region_col) + W'(2));

        // advance past the beat just taken
        col_n = col_0 + W'(1);
        row_n = row_0;
        if (col_n >= i_cfg.width) begin
            col_n = '0;
            row_n = row_0 + W'(1);
            if (row_n >= i_cfg.height) begin
                row_n = '0;
            end
        end
        n_col = col_n[conv3_pkg::COL_W-1:0];
        n_row = row_n[conv3_pkg::ROW_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

`ifndef SYNTHESIS
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> (r_col == '0
                   || r_col == $past(o_pos.col) + conv3_pkg::COL_W'(1)))
        else $error("column counter did not step by one or wrap");
`endif

endmodule

`default_nettype wire

// ===== src/conv3_line_ram.sv =====
`default_nettype none

module conv3_line_ram (
    input  wire                                 i_clk,
    input  wire                                 i_rd_en,
    input  wire  [conv3_pkg::COL_W-1:0]         i_rd_addr,
    output logic [conv3_pkg::LINE_W-1:0]        o_rd_data,
    input  wire                                 i_wr_en,
    input  wire  [conv3_pkg::COL_W-1:0]         i_wr_addr,
    input  wire  [conv3_pkg::LINE_W-1:0]        i_wr_data
);

    // word: two rows up in the high byte, one row up in the low byte
    logic [conv3_pkg::LINE_W-1:0] mem [0:conv3_pkg::MAX_WIDTH-1];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/conv3_mac.sv =====
`default_nettype none

module conv3_mac (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  conv3_pkg::t_cfg                  i_cfg,
    input  wire                              i_load,
    input  wire                              i_emit,
    input  wire  [conv3_pkg::PIX_W-1:0]      i_two_up,
    input  wire  [conv3_pkg::PIX_W-1:0]      i_one_up,
    input  wire  [conv3_pkg::PIX_W-1:0]      i_px,
    input  wire  [conv3_pkg::ROW_W-1:0]      i_row,
    input  wire  [conv3_pkg::COL_W-1:0]      i_col,
    output logic                             o_ready,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic [conv3_pkg::ROW_W-1:0]      o_row,
    output logic [conv3_pkg::COL_W-1:0]      o_col,
    output logic [conv3_pkg::PIX_W-1:0]      o_value
);

    localparam int PW = conv3_pkg::PROD_W;
    localparam int AW = conv3_pkg::ACC_W;

    logic [conv3_pkg::PIX_W-1:0] r_win [0:2][0:2];
    logic [conv3_pkg::PIX_W-1:0] n_win [0:2][0:2];

    logic                        r_v2;
    logic signed [PW-1:0]        r_prod [0:conv3_pkg::TAPS-1];
    logic signed [PW-1:0]        n_prod [0:conv3_pkg::TAPS-1];
    logic [conv3_pkg::ROW_W-1:0] r_row2;
    logic [conv3_pkg::COL_W-1:0] r_col2;

    logic                        r_v3;
    logic signed [AW-1:0]        r_acc;
    logic signed [AW-1:0]        n_acc;
    logic [conv3_pkg::ROW_W-1:0] r_row3;
    logic [conv3_pkg::COL_W-1:0] r_col3;

    logic                        r_ov;
    logic [conv3_pkg::PIX_W-1:0] r_oval;
    logic [conv3_pkg::PIX_W-1:0] n_oval;
    logic [conv3_pkg::ROW_W-1:0] r_orow;
    logic [conv3_pkg::COL_W-1:0] r_ocol;

    logic                        rdy2;
    logic                        rdy3;
    logic                        rdy4;
    logic [conv3_pkg::Q_W-1:0]   q;

    assign rdy4    = !r_ov || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign o_ready = rdy2;

    // window shift and the nine products of the shifted window
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i][0] = r_win[i][1];
            n_win[i][1] = r_win[i][2];
        end
        n_win[0][2] = i_two_up;
        n_win[1][2] = i_one_up;
        n_win[2][2] = i_px;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_prod[i*3+j] =
                    $signed({{(PW-conv3_pkg::PIX_W){1'b0}}, n_win[i][j]})
                  * $signed({{(PW-conv3_pkg::COEF_W){i_cfg.coef[i*3+j][conv3_pkg::COEF_W-1]}},
                             i_cfg.coef[i*3+j]});
            end
        end
    end

    always_comb begin
        n_acc = '0;
        for (int k = 0; k < conv3_pkg::TAPS; k++) begin
            n_acc = n_acc + AW'(r_prod[k]);
        end
    end

    // negative gives zero, otherwise drop the fraction and clamp
    always_comb begin
        q = r_acc[AW-1:conv3_pkg::COEF_FRAC_BITS];
        if (r_acc[AW-1]) begin
            n_oval = '0;
        end else if (q > conv3_pkg::Q_W'(i_cfg.max_sample)) begin
            n_oval = i_cfg.max_sample;
        end else begin
            n_oval = q[conv3_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_load) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy2) begin
                r_v2 <= i_load && i_emit;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_ov <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_load && i_emit) begin
            r_prod <= n_prod;
            r_row2 <= i_row;
            r_col2 <= i_col;
        end
        if (rdy3 && r_v2) begin
            r_acc  <= n_acc;
            r_row3 <= r_row2;
            r_col3 <= r_col2;
        end
        if (rdy4 && r_v3) begin
            r_oval <= n_oval;
            r_orow <= r_row3 - conv3_pkg::ROW_W'(1);
            r_ocol <= r_col3 - conv3_pkg::COL_W'(1);
        end
    end

    assign o_valid = r_ov;
    assign o_value = r_oval;
    assign o_row   = r_orow;
    assign o_col   = r_ocol;

`ifndef SYNTHESIS
    a_stage2_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !$past(r_v2)) |-> $past(i_load && i_emit))
        else $error("product stage filled without an emitting beat");

    a_out_from_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_v3))
        else $error("result appeared without a summed beat");
`endif

endmodule

`default_nettype wire
